// ----- src/kpm_pkg.sv -----
// ----------------------------------------------------------------------------
// kpm_pkg
// Shared types, sizes and codes for the KMP pattern matcher.
// ----------------------------------------------------------------------------
`default_nettype none

package kpm_pkg;

   // storage sizes
   localparam int PATTERN_MAX = 1024;
   localparam int TEXT_MAX    = 4096;

   // derived widths
   localparam int PAT_AW = $clog2(PATTERN_MAX);        // pattern store index
   localparam int LEN_W  = $clog2(PATTERN_MAX + 1);    // pattern length, 0..PATTERN_MAX
   localparam int TEXT_W = $clog2(TEXT_MAX);           // text index
   localparam int POS_W  = 12;                         // reported position field
   localparam int CALC_W = ((TEXT_W > LEN_W) ? TEXT_W : LEN_W) + 1;

   // request operations
   localparam logic [1:0] OP_PATTERN = 2'd0;
   localparam logic [1:0] OP_TEXT    = 2'd1;
   localparam logic [1:0] OP_END     = 2'd2;

   // result events
   localparam logic [1:0] EV_MATCH     = 2'd0;
   localparam logic [1:0] EV_END_NONE  = 2'd1;
   localparam logic [1:0] EV_END_FOUND = 2'd2;

   typedef struct packed {
      logic [1:0] operation;
      logic       start_pattern;
      logic [7:0] byte_value;
   } req_type;

   typedef struct packed {
      logic [1:0]       event_res;
      logic [POS_W-1:0] position;
   } rsp_type;

   // port of the pattern store
   typedef struct packed {
      logic              we;
      logic [PAT_AW-1:0] waddr;
      logic [7:0]        wdata;
      logic [PAT_AW-1:0] raddr;
   } pat_mem_type;

   // port of the failure table
   typedef struct packed {
      logic              we;
      logic [PAT_AW-1:0] waddr;
      logic [PAT_AW-1:0] wdata;
      logic [PAT_AW-1:0] raddr;
   } fail_mem_type;

   typedef enum logic [1:0] {
      ST_IDLE = 2'b01,
      ST_WALK = 2'b10
   } state_type;

endpackage

`default_nettype wire

// ----- src/kpm_ram.sv -----
// ----------------------------------------------------------------------------
// kpm_ram
// Generic single write, single read RAM with registered read data.
// ----------------------------------------------------------------------------
`default_nettype none

module kpm_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 1024
) (
   input  wire logic                     clock,
   input  wire logic                     wr_en,
   input  wire logic [$clog2(DEPTH)-1:0] wr_addr,
   input  wire logic [WIDTH-1:0]         wr_data,
   input  wire logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic      [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   // write port
   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
   end

   // registered read port
   always_ff @(posedge clock) begin
      rd_data_ff <= mem_ff[rd_addr];
   end

   assign rd_data = rd_data_ff;

endmodule

`default_nettype wire

// ----- src/kpm_engine.sv -----
// ----------------------------------------------------------------------------
// kpm_engine
// Sequencer of the matcher: takes requests, extends the failure table,
// walks the automaton through the two memories and holds the result register.
// ----------------------------------------------------------------------------
`default_nettype none

module kpm_engine (
   input  wire logic                  clock,
   input  wire logic                  reset,
   input  wire logic                  req_valid,
   output logic                       req_stall,
   input  wire kpm_pkg::req_type      req_payload,
   output logic                       rsp_valid,
   input  wire logic                  rsp_stall,
   output kpm_pkg::rsp_type           rsp_payload,
   output kpm_pkg::pat_mem_type       pat_port,
   input  wire logic [7:0]            pat_rd,
   output kpm_pkg::fail_mem_type      fail_port,
   input  wire logic [kpm_pkg::PAT_AW-1:0] fail_rd
);

   // control state
   kpm_pkg::state_type             state_ff, state_in;
   logic [kpm_pkg::LEN_W-1:0]      pat_len_ff, pat_len_in;
   logic [kpm_pkg::PAT_AW-1:0]     border_ff, border_in;
   logic [kpm_pkg::LEN_W-1:0]      matched_ff, matched_in;
   logic [kpm_pkg::TEXT_W-1:0]     text_pos_ff, text_pos_in;
   logic                           any_found_ff, any_found_in;
   logic                           rsp_valid_ff, rsp_valid_in;

   // per-request working registers
   logic                           is_text_ff, is_text_in;
   logic [7:0]                     char_ff, char_in;
   logic [kpm_pkg::TEXT_W-1:0]     idx_ff, idx_in;
   logic [kpm_pkg::PAT_AW-1:0]     walk_ff, walk_in;
   kpm_pkg::rsp_type               rsp_data_ff, rsp_data_in;

   logic                           accept;
   logic                           rsp_busy;
   logic [kpm_pkg::LEN_W-1:0]      final_len;
   logic [kpm_pkg::LEN_W-1:0]      q_start;
   logic [kpm_pkg::CALC_W-1:0]     idx_ext;
   logic [kpm_pkg::CALC_W-1:0]     len_m1;
   logic [kpm_pkg::CALC_W-1:0]     start_pos;

   assign rsp_busy  = rsp_valid_ff && rsp_stall;
   assign req_stall = (state_ff != kpm_pkg::ST_IDLE) ||
                      ((req_payload.operation == kpm_pkg::OP_END) && rsp_busy);
   assign accept    = req_valid && !req_stall;

   // length reached by the walk once the current character is compared
   assign final_len = kpm_pkg::LEN_W'(walk_ff) + kpm_pkg::LEN_W'(pat_rd == char_ff);

   // match state at the start of a text byte, cleared if out of range
   assign q_start = (matched_ff >= pat_len_ff) ? '0 : matched_ff;

   // start of a match, clamped at zero
   assign idx_ext   = kpm_pkg::CALC_W'(idx_ff);
   assign len_m1    = kpm_pkg::CALC_W'(pat_len_ff) - kpm_pkg::CALC_W'(1);
   assign start_pos = (idx_ext >= len_m1) ? (idx_ext - len_m1) : '0;

   // next state and memory accesses
   always_comb begin
      state_in     = state_ff;
      pat_len_in   = pat_len_ff;
      border_in    = border_ff;
      matched_in   = matched_ff;
      text_pos_in  = text_pos_ff;
      any_found_in = any_found_ff;
      is_text_in   = is_text_ff;
      char_in      = char_ff;
      idx_in       = idx_ff;
      walk_in      = walk_ff;
      rsp_data_in  = rsp_data_ff;
      rsp_valid_in = rsp_valid_ff && rsp_stall;

      pat_port.we     = 1'b0;
      pat_port.waddr  = pat_len_ff[kpm_pkg::PAT_AW-1:0];
      pat_port.wdata  = char_ff;
      pat_port.raddr  = walk_ff;
      fail_port.we    = 1'b0;
      fail_port.waddr = pat_len_ff[kpm_pkg::PAT_AW-1:0];
      fail_port.wdata = final_len[kpm_pkg::PAT_AW-1:0];
      fail_port.raddr = walk_ff - kpm_pkg::PAT_AW'(1);

      unique case (state_ff)
         kpm_pkg::ST_IDLE: begin
            if (accept) begin
               char_in = req_payload.byte_value;
               case (req_payload.operation)
                  kpm_pkg::OP_PATTERN: begin
                     is_text_in = 1'b0;
                     if (req_payload.start_pattern) begin
                        // new pattern: first byte has an empty border
                        pat_port.we     = 1'b1;
                        pat_port.waddr  = '0;
                        pat_port.wdata  = req_payload.byte_value;
                        fail_port.we    = 1'b1;
                        fail_port.waddr = '0;
                        fail_port.wdata = '0;
                        pat_len_in      = kpm_pkg::LEN_W'(1);
                        border_in       = '0;
                        matched_in      = '0;
                     end else if (pat_len_ff == '0) begin
                        pat_port.we     = 1'b1;
                        pat_port.waddr  = '0;
                        pat_port.wdata  = req_payload.byte_value;
                        fail_port.we    = 1'b1;
                        fail_port.waddr = '0;
                        fail_port.wdata = '0;
                        pat_len_in      = kpm_pkg::LEN_W'(1);
                        border_in       = '0;
                     end else if (pat_len_ff < kpm_pkg::LEN_W'(kpm_pkg::PATTERN_MAX)) begin
                        // store the byte, then walk from the current border
                        pat_port.we     = 1'b1;
                        pat_port.waddr  = pat_len_ff[kpm_pkg::PAT_AW-1:0];
                        pat_port.wdata  = req_payload.byte_value;
                        pat_port.raddr  = border_ff;
                        fail_port.raddr = border_ff - kpm_pkg::PAT_AW'(1);
                        walk_in         = border_ff;
                        state_in        = kpm_pkg::ST_WALK;
                     end
                  end
                  kpm_pkg::OP_TEXT: begin
                     is_text_in = 1'b1;
                     idx_in     = text_pos_ff;
                     if (text_pos_ff < kpm_pkg::TEXT_W'(kpm_pkg::TEXT_MAX - 1)) begin
                        text_pos_in = text_pos_ff + kpm_pkg::TEXT_W'(1);
                     end
                     if (pat_len_ff == '0) begin
                        matched_in = '0;
                     end else begin
                        pat_port.raddr  = q_start[kpm_pkg::PAT_AW-1:0];
                        fail_port.raddr = q_start[kpm_pkg::PAT_AW-1:0] - kpm_pkg::PAT_AW'(1);
                        walk_in         = q_start[kpm_pkg::PAT_AW-1:0];
                        state_in        = kpm_pkg::ST_WALK;
                     end
                  end
                  kpm_pkg::OP_END: begin
                     rsp_valid_in          = 1'b1;
                     rsp_data_in.event_res = any_found_ff ? kpm_pkg::EV_END_FOUND
                                                          : kpm_pkg::EV_END_NONE;
                     rsp_data_in.position  = '0;
                     text_pos_in           = '0;
                     matched_in            = '0;
                     any_found_in          = 1'b0;
                  end
                  default: begin
                  end
               endcase
            end
         end
         kpm_pkg::ST_WALK: begin
            if ((walk_ff != '0) && (pat_rd != char_ff)) begin
               // fall back through the failure table
               walk_in         = fail_rd;
               pat_port.raddr  = fail_rd;
               fail_port.raddr = fail_rd - kpm_pkg::PAT_AW'(1);
            end else if (!is_text_ff) begin
               // border of the extended pattern
               fail_port.we = 1'b1;
               border_in    = final_len[kpm_pkg::PAT_AW-1:0];
               pat_len_in   = pat_len_ff + kpm_pkg::LEN_W'(1);
               state_in     = kpm_pkg::ST_IDLE;
            end else if (final_len == pat_len_ff) begin
               // full match: report it once the result register is free
               if (!rsp_busy) begin
                  rsp_valid_in          = 1'b1;
                  rsp_data_in.event_res = kpm_pkg::EV_MATCH;
                  rsp_data_in.position  = kpm_pkg::POS_W'(start_pos);
                  any_found_in          = 1'b1;
                  matched_in            = kpm_pkg::LEN_W'(border_ff);
                  state_in              = kpm_pkg::ST_IDLE;
               end
            end else begin
               matched_in = final_len;
               state_in   = kpm_pkg::ST_IDLE;
            end
         end
         default: begin
            state_in = kpm_pkg::ST_IDLE;
         end
      endcase
   end

   // control registers
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= kpm_pkg::ST_IDLE;
         pat_len_ff   <= '0;
         border_ff    <= '0;
         matched_ff   <= '0;
         text_pos_ff  <= '0;
         any_found_ff <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         pat_len_ff   <= pat_len_in;
         border_ff    <= border_in;
         matched_ff   <= matched_in;
         text_pos_ff  <= text_pos_in;
         any_found_ff <= any_found_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   // working and payload registers
   always_ff @(posedge clock) begin
      is_text_ff  <= is_text_in;
      char_ff     <= char_in;
      idx_ff      <= idx_in;
      walk_ff     <= walk_in;
      rsp_data_ff <= rsp_data_in;
   end

   assign rsp_valid   = rsp_valid_ff;
   assign rsp_payload = rsp_data_ff;

endmodule

`default_nettype wire

// ----- src/kmp_pattern_matcher_unit.sv -----
// ----------------------------------------------------------------------------
// kmp_pattern_matcher_unit
// Knuth-Morris-Pratt matcher: pattern bytes build the failure table online,
// text bytes stream through the automaton and report match start positions.
//
//   channel   ports                        direction   payload
//   request   req_valid/req_stall          in          kpm_pkg::req_type
//   response  rsp_valid/rsp_stall          out         kpm_pkg::rsp_type
//
// A pattern or text byte that walks the table falls back through the
// failure table in the walk state, one registered read of the pattern
// store and failure table per step. End-of-text, unused operations,
// dropped pattern bytes, the first byte of a pattern and text bytes
// against an empty pattern are handled in the idle state with no walk.
// Reset clears lengths, match state and text position; the memories are
// only used below the stored pattern length, so they need no clearing.
// A stalled response holds a finished match in the walk state, and an
// end-of-text request waits while the response register is full and stalled.
// ----------------------------------------------------------------------------
`default_nettype none

module kmp_pattern_matcher_unit (
   input  wire logic             clock,
   input  wire logic             reset,
   input  wire logic             req_valid,
   output logic                  req_stall,
   input  wire kpm_pkg::req_type req_payload,
   output logic                  rsp_valid,
   input  wire logic             rsp_stall,
   output kpm_pkg::rsp_type      rsp_payload
);

   kpm_pkg::pat_mem_type          pat_port;
   kpm_pkg::fail_mem_type         fail_port;
   logic [7:0]                    pat_rd;
   logic [kpm_pkg::PAT_AW-1:0]    fail_rd;

   // sequencer
   kpm_engine u_engine (
      .clock       (clock),
      .reset       (reset),
      .req_valid   (req_valid),
      .req_stall   (req_stall),
      .req_payload (req_payload),
      .rsp_valid   (rsp_valid),
      .rsp_stall   (rsp_stall),
      .rsp_payload (rsp_payload),
      .pat_port    (pat_port),
      .pat_rd      (pat_rd),
      .fail_port   (fail_port),
      .fail_rd     (fail_rd)
   );

   // pattern store
   kpm_ram #(
      .WIDTH (8),
      .DEPTH (kpm_pkg::PATTERN_MAX)
   ) u_pat_ram (
      .clock   (clock),
      .wr_en   (pat_port.we),
      .wr_addr (pat_port.waddr),
      .wr_data (pat_port.wdata),
      .rd_addr (pat_port.raddr),
      .rd_data (pat_rd)
   );

   // failure table
   kpm_ram #(
      .WIDTH (kpm_pkg::PAT_AW),
      .DEPTH (kpm_pkg::PATTERN_MAX)
   ) u_fail_ram (
      .clock   (clock),
      .wr_en   (fail_port.we),
      .wr_addr (fail_port.waddr),
      .wr_data (fail_port.wdata),
      .rd_addr (fail_port.raddr),
      .rd_data (fail_rd)
   );

endmodule

`default_nettype wire
